// ----- src/i2a_pkg.sv -----
// Package for the integer-to-ASCII converter: widths, digit counts, radix codes
// and the digit-to-character function. Depends on nothing.
package i2a_pkg;

  // Width of the value that is converted; bits of the input above it are ignored.
  localparam int VALUE_WIDTH = 64;

  // Digit counts for each base at this width.
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  // ceil(VALUE_WIDTH * log10(2)); the product is never a whole number.
  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

  // The digit register holds the longest digit string, which is octal.
  localparam int SLOTS = OCT_DIGITS;
  localparam int DIG_W = SLOTS * 4;
  localparam int REM_W = $clog2(SLOTS + 1);

  // Binary-to-BCD unit: four bits per cycle.
  localparam int DAB_STEPS = (VALUE_WIDTH + 3) / 4;
  localparam int DAB_PAD_W = DAB_STEPS * 4;
  localparam int DAB_CNT_W = $clog2(DAB_STEPS + 1);
  localparam int BCD_W     = DEC_DIGITS * 4;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2
  } radix_t;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic up);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end else if (up) begin
      return CH_UPPER_A + d8 - 8'd10;
    end else begin
      return CH_LOWER_A + d8 - 8'd10;
    end
  endfunction

endpackage

// ----- src/i2a_dabble.sv -----
// Iterative binary-to-BCD converter (shift and add-3), four bits per cycle.
// Depends on i2a_pkg.
module i2a_dabble
  import i2a_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [VALUE_WIDTH-1:0] bin_in,
  output logic                   done,
  output logic [BCD_W-1:0]       bcd
);

  logic [DAB_PAD_W-1:0] bin_reg;
  logic [DAB_CNT_W-1:0] cnt;
  logic [BCD_W-1:0]     bcd_next;
  logic [DAB_PAD_W-1:0] bin_next;

  // Four shift steps; the digit corrections within one step are independent.
  always_comb begin
    bcd_next = bcd;
    bin_next = bin_reg;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < DEC_DIGITS; k++) begin
        if (bcd_next[k*4 +: 4] >= 4'd5) begin
          bcd_next[k*4 +: 4] = bcd_next[k*4 +: 4] + 4'd3;
        end
      end
      {bcd_next, bin_next} = {bcd_next[BCD_W-2:0], bin_next, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt <= DAB_CNT_W'(DAB_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DAB_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      bin_reg <= DAB_PAD_W'(bin_in);
      bcd     <= '0;
    end else if (cnt != '0) begin
      bin_reg <= bin_next;
      bcd     <= bcd_next;
    end
  end

endmodule

// ----- src/integer_to_ascii_radix_top.sv -----
// Integer-to-ASCII converter, top level: sequencer, digit register and output word.
// The first word follows the load, the binary-to-BCD conversion (decimal only) and the
// leading-zero skip; words then go out one per cycle, sign first, and the receiver cannot
// stall, so nothing else waits. Busy stays high from an accepted start until the final
// word goes out; no new number is taken while busy. Synchronous active-high reset
// returns to idle with no word pending.
module integer_to_ascii_radix_top
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic        sign_mode,
  input  logic [1:0]  radix_sel,
  input  logic        upper_case,
  output logic        char_valid,
  output logic [7:0]  char_code,
  output logic        last
);

  // The sequencer walks a load, an optional BCD conversion, a leading-zero
  // skip, an optional sign word and then one digit word per cycle.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                 state;
  logic [DIG_W-1:0]       dig;        // digit slots, most significant at the top
  logic [REM_W-1:0]       remaining;  // digits still in the register
  logic                   upper;
  logic                   neg_pend;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] v_in;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   dec_sel;
  logic                   dab_done;
  logic [BCD_W-1:0]       bcd;
  logic [OCT_DIGITS*3-1:0] oct_pad;
  logic [OCT_DIGITS*4-1:0] oct_slots;
  logic [3:0]             top_digit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // The magnitude is the two's-complement negation within the value width,
  // so the most negative value comes out with its full magnitude.
  assign v_in   = value[VALUE_WIDTH-1:0];
  assign neg_in = sign_mode && v_in[VALUE_WIDTH-1];
  assign mag    = neg_in ? (~v_in + VALUE_WIDTH'(1)) : v_in;

  always_comb begin
    case (radix_t'(radix_sel))
      RADIX_HEX: dec_sel = 1'b0;
      RADIX_OCT: dec_sel = 1'b0;
      default:   dec_sel = 1'b1;  // decimal, and the unused code reads as decimal
    endcase
  end

  // Octal digits are three bits wide; spread them over the four-bit slots.
  assign oct_pad = (OCT_DIGITS*3)'(mag);
  always_comb begin
    for (int i = 0; i < OCT_DIGITS; i++) begin
      oct_slots[i*4 +: 4] = {1'b0, oct_pad[i*3 +: 3]};
    end
  end

  assign top_digit = dig[DIG_W-1 -: 4];

  i2a_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .go     (accept && dec_sel),
    .bin_in (mag),
    .done   (dab_done),
    .bcd    (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
    end else begin
      char_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= dec_sel ? S_CONV : S_SKIP;
          end
        end
        S_CONV: begin
          if (dab_done) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          // Leading zeros go one per cycle; the last digit always stays.
          if (top_digit == 4'd0 && remaining != REM_W'(1)) begin
            state <= S_SKIP;
          end else if (neg_pend) begin
            state <= S_SIGN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_SIGN: begin
          char_valid <= 1'b1;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          char_valid <= 1'b1;
          if (remaining == REM_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers carry no reset; the sequencer decides when they matter.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          upper    <= upper_case;
          neg_pend <= neg_in;
          if (radix_t'(radix_sel) == RADIX_HEX) begin
            dig       <= DIG_W'((HEX_DIGITS*4)'(mag)) << ((SLOTS - HEX_DIGITS) * 4);
            remaining <= REM_W'(HEX_DIGITS);
          end else if (radix_t'(radix_sel) == RADIX_OCT) begin
            dig       <= DIG_W'(oct_slots) << ((SLOTS - OCT_DIGITS) * 4);
            remaining <= REM_W'(OCT_DIGITS);
          end
        end
      end
      S_CONV: begin
        if (dab_done) begin
          dig       <= DIG_W'(bcd) << ((SLOTS - DEC_DIGITS) * 4);
          remaining <= REM_W'(DEC_DIGITS);
        end
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && remaining != REM_W'(1)) begin
          dig       <= dig << 4;
          remaining <= remaining - 1'b1;
        end
      end
      S_SIGN: begin
        char_code <= CH_MINUS;
        last      <= 1'b0;
      end
      S_EMIT: begin
        char_code <= digit_ascii(top_digit, upper);
        last      <= (remaining == REM_W'(1));
        dig       <= dig << 4;
        remaining <= remaining - 1'b1;
      end
      default: begin
        upper <= upper;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted word always leaves idle on the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("block did not leave idle after start");

  // The final word of a number is never followed at once by another word.
  assert property (@(posedge clk) disable iff (rst) (char_valid && last) |=> !char_valid)
    else $error("word emitted right after the final character");

  // Emission only runs while at least one digit is left.
  assert property (@(posedge clk) disable iff (rst) (state == S_EMIT) |-> (remaining != '0))
    else $error("digit emitted from an empty digit register");

  // A digit word is always a digit, a hex letter or the minus sign.
  assert property (@(posedge clk) disable iff (rst)
    char_valid |-> ((char_code >= 8'h30 && char_code <= 8'h39) ||
                    (char_code >= 8'h41 && char_code <= 8'h46) ||
                    (char_code >= 8'h61 && char_code <= 8'h66) ||
                    (char_code == 8'h2D)))
    else $error("character outside the digit set");
`endif

endmodule

// ----- verif/i2a_char_checker.sv -----
// Character checker for the integer-to-ASCII converter: predicts the characters of
// every accepted number and compares each emitted word with the oldest one waiting.
// Depends on i2a_pkg for VALUE_WIDTH and the radix codes.
`timescale 1ns / 100ps

module i2a_char_checker
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] value,
  input  logic        sign_mode,
  input  logic [1:0]  radix_sel,
  input  logic        upper_case,
  input  logic        char_valid,
  input  logic [7:0]  char_code,
  input  logic        last,
  output int          errors,
  output int          chars_pending,
  output int          chars_checked
);

  localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
  localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";
  localparam logic [7:0]   MINUS_SIGN   = "-";

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } ascii_char_t;

  ascii_char_t expected_chars[$];

  initial begin
    errors = 0;
    chars_checked = 0;
    chars_pending = 0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Queues the characters of one number: an optional minus sign, then the digits
  // of the magnitude, most significant first, with the final one marked.
  function automatic void predict_chars(input logic [63:0] raw, input logic sgn,
                                        input logic [1:0] sel, input logic up);
    logic [63:0] wmask;
    logic [63:0] mag;
    logic [63:0] base;
    logic        neg;
    int          d;
    int          i;
    logic [7:0]  digits_lsd_first[$];

    wmask = {64{1'b1}} >> (64 - VALUE_WIDTH);
    mag   = raw & wmask;
    neg   = sgn && mag[VALUE_WIDTH-1];
    if (neg) begin
      mag = (64'd0 - mag) & wmask;
    end

    if (sel == RADIX_HEX) begin
      base = 64'd16;
    end else if (sel == RADIX_OCT) begin
      base = 64'd8;
    end else begin
      base = 64'd10;
    end

    do begin
      d   = int'(mag % base);
      mag = mag / base;
      digits_lsd_first.push_back(up ? UPPER_DIGITS[127 - 8*d -: 8]
                                    : LOWER_DIGITS[127 - 8*d -: 8]);
    end while (mag != 64'd0);

    if (neg) begin
      expected_chars.push_back('{code: MINUS_SIGN, fin: 1'b0});
    end
    for (i = digits_lsd_first.size() - 1; i >= 0; i--) begin
      expected_chars.push_back('{code: digits_lsd_first[i], fin: (i == 0)});
    end
  endfunction

  always @(posedge clk) begin
    ascii_char_t want;
    if (!rst) begin
      if (start && !busy) begin
        predict_chars(value, sign_mode, radix_sel, upper_case);
      end
      if (char_valid) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%h (last %b) with none expected",
                                    char_code, last));
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code) begin
            report_mismatch($sformatf("char_code 0x%h, expected 0x%h '%c'",
                                      char_code, want.code, want.code));
          end
          if (last !== want.fin) begin
            report_mismatch($sformatf("last %b on char 0x%h, expected %b",
                                      last, want.code, want.fin));
          end
        end
      end
    end
    chars_pending <= expected_chars.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the integer-to-ASCII converter: clock, reset, number stimulus,
// watchdog and verdict. Depends on i2a_pkg, integer_to_ascii_radix_top and i2a_char_checker.
`timescale 1ns / 100ps

module tb_top
  import i2a_pkg::*;
();

  // The spare radix code is not listed in the package; the block treats it as decimal.
  localparam logic [1:0] RADIX_SPARE = 2'd3;

  localparam int RANDOM_NUMBERS = 160;
  // Cycles with no word moving on either side before the run is declared hung.
  localparam int IDLE_LIMIT     = 1000;
  // Quiet time after the last expected character, to catch stray output words.
  localparam int DRAIN_CYCLES   = 64;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] value;
  logic        sign_mode;
  logic [1:0]  radix_sel;
  logic        upper_case;
  logic        char_valid;
  logic [7:0]  char_code;
  logic        last;

  int mismatches;
  int chars_pending;
  int chars_checked;

  // Sender pacing: numbers left in the current burst, and numbers sent per radix code.
  int burst_left = 0;
  int sent_per_radix[4] = '{0, 0, 0, 0};

  integer_to_ascii_radix_top u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .sign_mode  (sign_mode),
    .radix_sel  (radix_sel),
    .upper_case (upper_case),
    .char_valid (char_valid),
    .char_code  (char_code),
    .last       (last)
  );

  // The checker sees both channels exactly as the block does and owns all prediction.
  i2a_char_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .sign_mode     (sign_mode),
    .radix_sel     (radix_sel),
    .upper_case    (upper_case),
    .char_valid    (char_valid),
    .char_code     (char_code),
    .last          (last),
    .errors        (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends one number. Before it, the sender may end its burst and pause for a random
  // gap; gaps start right after an accepted word, so they land on every phase of the
  // block's work. Within a burst start stays high and only the fields change, and the
  // word is taken at the first edge where busy is low.
  task automatic send_number(input logic [63:0] v, input logic sgn, input logic [1:0] r,
                             input logic up);
    int gap_max;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap_max = ($urandom_range(0, 3) == 0) ? 60 : 8;
      start <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      // Some bursts are long, so there are stretches with no idling at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 25)
                                               : $urandom_range(0, 6);
    end
    value      <= v;
    sign_mode  <= sgn;
    radix_sel  <= r;
    upper_case <= up;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    sent_per_radix[r]++;
  endtask

  initial begin
    int          k;
    logic [63:0] v;
    logic [1:0]  r;

    rst        <= 1'b1;
    start      <= 1'b0;
    value      <= 64'd0;
    sign_mode  <= 1'b0;
    radix_sel  <= RADIX_DEC;
    upper_case <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed numbers. Zero must print as a single digit in every base.
    send_number(64'd0, 1'b0, RADIX_DEC, 1'b0);
    send_number(64'd0, 1'b1, RADIX_HEX, 1'b1);
    send_number(64'd0, 1'b0, RADIX_OCT, 1'b0);
    // All ones: the longest unsigned strings, and -1 when read as signed.
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, RADIX_DEC, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, RADIX_HEX, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, RADIX_HEX, 1'b1);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, RADIX_OCT, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, RADIX_DEC, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, RADIX_HEX, 1'b1);
    // The most negative value negates to itself; its octal form is the longest result.
    send_number(64'h8000_0000_0000_0000, 1'b1, RADIX_DEC, 1'b0);
    send_number(64'h8000_0000_0000_0000, 1'b1, RADIX_HEX, 1'b0);
    send_number(64'h8000_0000_0000_0000, 1'b1, RADIX_OCT, 1'b0);
    send_number(64'h8000_0000_0000_0000, 1'b0, RADIX_DEC, 1'b0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, RADIX_DEC, 1'b0);
    // Every hex letter in both cases.
    send_number(64'hFEDC_BA98_7654_3210, 1'b0, RADIX_HEX, 1'b1);
    send_number(64'hFEDC_BA98_7654_3210, 1'b0, RADIX_HEX, 1'b0);
    // The spare radix code must behave as decimal, signed or not.
    send_number(64'd1234567890, 1'b0, RADIX_SPARE, 1'b0);
    send_number(64'hFFFF_FFFF_B669_FD2E, 1'b1, RADIX_SPARE, 1'b1);
    // The case flag must have no visible effect outside hex.
    send_number(64'h0000_0000_DEAD_BEEF, 1'b0, RADIX_DEC, 1'b1);
    send_number(64'h0000_0000_DEAD_BEEF, 1'b0, RADIX_OCT, 1'b1);
    // One and two digit numbers around the decimal and hex bases, and octal 8.
    send_number(64'd9, 1'b0, RADIX_DEC, 1'b0);
    send_number(64'd10, 1'b1, RADIX_DEC, 1'b0);
    send_number(64'd15, 1'b0, RADIX_HEX, 1'b0);
    send_number(64'd16, 1'b0, RADIX_HEX, 1'b1);
    send_number(64'd8, 1'b1, RADIX_OCT, 1'b0);

    // Random numbers. The value shapes are mixed so that digit counts, leading-zero
    // skips and sign handling all vary, not just full-width random values.
    for (k = 0; k < RANDOM_NUMBERS; k++) begin
      v = {$urandom(), $urandom()};
      case ($urandom_range(0, 5))
        0: v = 64'($urandom_range(0, 99));
        1: v = v >> $urandom_range(1, 63);
        2: v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
        3: v = ~(v >> $urandom_range(1, 63));
        default: ;
      endcase
      r = ($urandom_range(0, 7) == 0) ? RADIX_SPARE : 2'($urandom_range(0, 2));
      send_number(v, 1'($urandom_range(0, 1)), r, 1'($urandom_range(0, 1)));
    end
    start <= 1'b0;

    // The count of waiting characters is registered, so let it catch up with the last
    // number before trusting it.
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers: %0d decimal, %0d hex, %0d octal, %0d spare code.",
             sent_per_radix[0] + sent_per_radix[1] + sent_per_radix[2] + sent_per_radix[3],
             sent_per_radix[RADIX_DEC], sent_per_radix[RADIX_HEX],
             sent_per_radix[RADIX_OCT], sent_per_radix[RADIX_SPARE]);
    $display("Checked %0d characters, %0d mismatches.", chars_checked, mismatches);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: any cycle in which neither a number nor a character moves counts as idle.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy && !rst) || char_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no word moved for %0d cycles, %0d characters still expected.",
             IDLE_LIMIT, chars_pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
